// ----- rtl/jcc_pkg.sv -----
package jcc_pkg;

  // Most output bytes that one bundle can hold for an input word, and derived widths.
  localparam int MAX_OUT = 8;
  localparam int POS_W   = $clog2(MAX_OUT);
  localparam int CNT_W   = $clog2(MAX_OUT + 1);

  // Bundles held between the front and the back.
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  // The conversion rules never emit more than this many bytes for one word.
  localparam int WORST_BURST = 5;

  // Byte codes that the conversions test for or emit.
  localparam logic [7:0] ESC       = 8'h1b;
  localparam logic [7:0] SS2       = 8'h8e;
  localparam logic [7:0] HI_BIT    = 8'h80;
  localparam logic [7:0] LOW7_MASK = 8'h7f;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_B      = 8'h42;
  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_J      = 8'h4a;

  typedef enum logic [1:0] {
    MODE_EUC_SJIS = 2'd0,
    MODE_SJIS_EUC = 2'd1,
    MODE_EUC_JIS  = 2'd2,
    MODE_JIS_EUC  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    CS_NONE  = 3'd0,
    CS_ASCII = 3'd1,
    CS_ROMAN = 3'd2,
    CS_KANJI = 3'd3,
    CS_KANA  = 3'd4
  } charset_t;

  typedef enum logic [1:0] {
    CL_NONE  = 2'd0,
    CL_ASCII = 2'd1,
    CL_KANJI = 2'd2,
    CL_KANA  = 2'd3
  } class_t;

  // All output bytes caused by one input word and their count; the back marks the last one.
  typedef struct packed {
    logic [MAX_OUT-1:0][7:0] bytes;
    logic [CNT_W-1:0]        cnt;
  } bundle_t;

  // Front status, watched at the top level.
  typedef struct packed {
    logic [1:0] held_cnt;
    charset_t   charset;
  } front_stat_t;

  function automatic bundle_t bundle_put(bundle_t bd, logic [7:0] b);
    bundle_t r;
    r = bd;
    if (bd.cnt < CNT_W'(MAX_OUT)) begin
      r.bytes[bd.cnt[POS_W-1:0]] = b;
      r.cnt = bd.cnt + CNT_W'(1);
    end
    return r;
  endfunction

endpackage

// ----- rtl/jcc_front.sv -----
module jcc_front
  import jcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_mode,
  input  logic        accept,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        push_valid,
  output bundle_t     push_data,
  output front_stat_t stat
);

  mode_t      mode_r;
  logic [7:0] h0_r, h1_r, h2_r;
  logic [7:0] h0_nxt, h1_nxt, h2_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  charset_t   cs_r, cs_nxt;
  class_t     ecls_r, ecls_nxt;
  logic       ae_r, ae_nxt;
  bundle_t    bd;

  logic       do_char, char_after, do_fresh, ok;
  charset_t   char_cs, cs_esc;
  logic [7:0] hi, lo, sl, sh;

  // Escape sequence announcing a change of character class.
  function automatic bundle_t put_class(bundle_t bdi, class_t cls, class_t cur);
    bundle_t r;
    r = bdi;
    if (cls != cur) begin
      r = bundle_put(r, ESC);
      case (cls)
        CL_KANA: begin
          r = bundle_put(r, CH_LPAREN);
          r = bundle_put(r, CH_I);
        end
        CL_KANJI: begin
          r = bundle_put(r, CH_DOLLAR);
          r = bundle_put(r, CH_B);
        end
        default: begin
          r = bundle_put(r, CH_LPAREN);
          r = bundle_put(r, CH_B);
        end
      endcase
    end
    return r;
  endfunction

  function automatic charset_t parse_escape(logic [7:0] s, logic [7:0] t);
    charset_t r;
    r = CS_NONE;
    if (s == CH_DOLLAR && (t == CH_B || t == CH_AT)) r = CS_KANJI;
    else if (s == CH_LPAREN && t == CH_J) r = CS_ROMAN;
    else if (s == CH_LPAREN && t == CH_I) r = CS_KANA;
    else if (s == CH_LPAREN && t == CH_B) r = CS_ASCII;
    return r;
  endfunction

  always_comb begin
    bd         = '0;
    h0_nxt     = h0_r;
    h1_nxt     = h1_r;
    h2_nxt     = h2_r;
    cnt_nxt    = cnt_r;
    cs_nxt     = cs_r;
    ecls_nxt   = ecls_r;
    ae_nxt     = ae_r;
    do_char    = 1'b0;
    char_after = 1'b0;
    char_cs    = cs_r;
    cs_esc     = CS_NONE;
    do_fresh   = 1'b0;
    ok         = 1'b0;
    hi         = h0_r & LOW7_MASK;
    lo         = in_byte & LOW7_MASK;
    sl         = '0;
    sh         = '0;

    if (mode_r == MODE_JIS_EUC) begin
      case (cnt_r)
        2'd0: begin
          if (in_byte == ESC) begin
            h0_nxt  = in_byte;
            cnt_nxt = 2'd1;
            ae_nxt  = 1'b0;
          end else begin
            do_char = 1'b1;
          end
        end
        2'd1: begin
          if (h0_r == ESC && !ae_r) begin
            h1_nxt  = in_byte;
            cnt_nxt = 2'd2;
          end else begin
            bd      = bundle_put(bd, h0_r | HI_BIT);
            bd      = bundle_put(bd, in_byte | HI_BIT);
            cnt_nxt = 2'd0;
            ae_nxt  = 1'b0;
          end
        end
        2'd2: begin
          h2_nxt  = in_byte;
          cnt_nxt = 2'd3;
        end
        default: begin
          // Complete escape: designate, then take this byte as the first character.
          cs_esc     = parse_escape(h1_r, h2_r);
          cs_nxt     = cs_esc;
          char_cs    = cs_esc;
          if (cs_esc == CS_KANJI && (in_byte inside {[8'ha0:8'hdf]})) char_cs = CS_KANA;
          cnt_nxt    = 2'd0;
          do_char    = 1'b1;
          char_after = 1'b1;
        end
      endcase
      if (do_char) begin
        if (char_cs == CS_KANA) begin
          bd = bundle_put(bd, SS2);
          bd = bundle_put(bd, in_byte | HI_BIT);
        end else if (char_cs == CS_KANJI) begin
          h0_nxt  = in_byte;
          cnt_nxt = 2'd1;
          ae_nxt  = char_after;
        end else begin
          bd = bundle_put(bd, in_byte);
        end
      end
    end else begin
      if (cnt_r != 2'd0) begin
        cnt_nxt = 2'd0;
        case (mode_r)
          MODE_EUC_SJIS: begin
            if ((h0_r inside {[8'ha1:8'hfe]}) && (in_byte inside {[8'ha1:8'hfe]})) begin
              sl = lo + (hi[0] ? 8'h1f : 8'h7d);
              if (sl >= 8'h7f) sl = sl + 8'd1;
              sh = ((hi - 8'h21) >> 1) + 8'h81;
              if (sh > 8'h9f) sh = sh + 8'h40;
              bd = bundle_put(bd, sh);
              bd = bundle_put(bd, sl);
              ok = 1'b1;
            end else if (h0_r == SS2 && (in_byte inside {[8'ha0:8'hdf]})) begin
              bd = bundle_put(bd, in_byte);
              ok = 1'b1;
            end
          end
          MODE_SJIS_EUC: begin
            if ((in_byte inside {[8'h40:8'hfc]}) && in_byte != 8'h7f) begin
              sh = h0_r - ((h0_r <= 8'h9f) ? 8'h71 : 8'hb1);
              sh = {sh[6:0], 1'b1};
              sl = in_byte;
              if (sl >= 8'h9f) begin
                sl = sl - 8'h7e;
                sh = sh + 8'd1;
              end else if (sl > 8'h7f) begin
                sl = sl - 8'h20;
              end else begin
                sl = sl - 8'h1f;
              end
              bd = bundle_put(bd, sh | HI_BIT);
              bd = bundle_put(bd, sl | HI_BIT);
              ok = 1'b1;
            end
          end
          default: begin
            if ((h0_r inside {[8'ha1:8'hfe]}) && (in_byte inside {[8'ha1:8'hfe]})) begin
              bd       = put_class(bd, CL_KANJI, ecls_nxt);
              ecls_nxt = CL_KANJI;
              bd       = bundle_put(bd, hi);
              bd       = bundle_put(bd, lo);
              ok       = 1'b1;
            end else if (h0_r == SS2 && (in_byte inside {[8'ha0:8'hdf]})) begin
              bd       = put_class(bd, CL_KANA, ecls_nxt);
              ecls_nxt = CL_KANA;
              bd       = bundle_put(bd, lo);
              ok       = 1'b1;
            end
          end
        endcase
        if (!ok) begin
          // The held byte did not pair: it goes out alone, the new byte starts afresh.
          if (mode_r == MODE_EUC_JIS) begin
            bd       = put_class(bd, CL_ASCII, ecls_nxt);
            ecls_nxt = CL_ASCII;
          end
          bd       = bundle_put(bd, h0_r);
          do_fresh = 1'b1;
        end
      end else begin
        do_fresh = 1'b1;
      end

      if (do_fresh) begin
        case (mode_r)
          MODE_SJIS_EUC: begin
            if (in_byte inside {[8'ha0:8'hdf]}) begin
              bd = bundle_put(bd, SS2);
              bd = bundle_put(bd, in_byte);
            end else if (in_byte inside {[8'h81:8'h9f], [8'he0:8'hfc]}) begin
              h0_nxt  = in_byte;
              cnt_nxt = 2'd1;
            end else begin
              bd = bundle_put(bd, in_byte);
            end
          end
          default: begin
            if ((in_byte inside {[8'ha1:8'hfe]}) || in_byte == SS2) begin
              h0_nxt  = in_byte;
              cnt_nxt = 2'd1;
            end else begin
              if (mode_r == MODE_EUC_JIS) begin
                bd       = put_class(bd, CL_ASCII, ecls_nxt);
                ecls_nxt = CL_ASCII;
              end
              bd = bundle_put(bd, in_byte);
            end
          end
        endcase
      end
    end

    if (in_last) begin
      // End of text: flush a held lead byte, drop a partial escape.
      if (cnt_nxt != 2'd0) begin
        if (mode_r == MODE_JIS_EUC) begin
          if (cnt_nxt == 2'd1 && (h0_nxt != ESC || ae_nxt)) begin
            bd = bundle_put(bd, h0_nxt | HI_BIT);
            bd = bundle_put(bd, HI_BIT);
          end
        end else begin
          if (mode_r == MODE_EUC_JIS) begin
            bd       = put_class(bd, CL_ASCII, ecls_nxt);
            ecls_nxt = CL_ASCII;
          end
          bd = bundle_put(bd, h0_nxt);
        end
      end
      cnt_nxt  = 2'd0;
      cs_nxt   = CS_NONE;
      ecls_nxt = CL_NONE;
      ae_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_EUC_SJIS;
      cnt_r  <= 2'd0;
      cs_r   <= CS_NONE;
      ecls_r <= CL_NONE;
      ae_r   <= 1'b0;
    end else if (cfg_we) begin
      mode_r <= mode_t'(cfg_mode);
      cnt_r  <= 2'd0;
      cs_r   <= CS_NONE;
      ecls_r <= CL_NONE;
      ae_r   <= 1'b0;
    end else if (accept) begin
      cnt_r  <= cnt_nxt;
      cs_r   <= cs_nxt;
      ecls_r <= ecls_nxt;
      ae_r   <= ae_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      h0_r <= h0_nxt;
      h1_r <= h1_nxt;
      h2_r <= h2_nxt;
    end
  end

  assign push_valid    = accept && (bd.cnt != '0);
  assign push_data     = bd;
  assign stat.held_cnt = cnt_r;
  assign stat.charset  = cs_r;

endmodule

// ----- rtl/jcc_queue.sv -----
module jcc_queue
  import jcc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  bundle_t wdata,
  output logic    full,
  input  logic    pop,
  output logic    not_empty,
  output bundle_t rdata
);

  bundle_t           mem_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  function automatic logic [Q_AW-1:0] ptr_inc(logic [Q_AW-1:0] p);
    return (p == Q_AW'(Q_DEPTH - 1)) ? '0 : p + Q_AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop) rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop) count_r <= count_r + QCNT_W'(1);
      else if (pop && !push) count_r <= count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

  assign full      = (count_r == QCNT_W'(Q_DEPTH));
  assign not_empty = (count_r != '0);
  assign rdata     = mem_r[rd_ptr_r];

endmodule

// ----- rtl/jcc_back.sv -----
module jcc_back
  import jcc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  bundle_t    q_data,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  bundle_t          cur_r;
  logic [POS_W-1:0] pos_r;
  logic             busy_r;
  logic             final_byte, done, load;

  assign final_byte = (CNT_W'(pos_r) + CNT_W'(1) == cur_r.cnt);
  assign done       = busy_r && out_ready && final_byte;
  assign load       = q_valid && (!busy_r || done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pos_r  <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      pos_r  <= '0;
    end else if (done) begin
      busy_r <= 1'b0;
    end else if (busy_r && out_ready) begin
      pos_r <= pos_r + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) cur_r <= q_data;
  end

  assign q_pop     = load;
  assign out_valid = busy_r;
  assign out_byte  = cur_r.bytes[pos_r];
  assign out_last  = final_byte;

endmodule

// ----- rtl/japanese_charset_converter_top.sv -----
// Japanese text converter. Each input word is one byte of source text; conv_mode selects
// EUC-JP to Shift_JIS, Shift_JIS to EUC-JP, EUC-JP to ISO-2022-JP or ISO-2022-JP to
// EUC-JP. A possible lead byte (or an escape prefix) is held until the next word shows
// what it is, and in_last flushes held bytes and returns the charset state to undetermined.
// The front accepts one input word every cycle while its two-entry bundle queue has room;
// each word turns into zero to five output words, which the back sends one per cycle while
// out_ready is high, so throughput is one input word per cycle when each word yields at
// most one output word and otherwise is set by the number of output words. Each bundle is
// queued, then registered in the back. out_last marks the last output word of an input word.
// Write conv_mode only when the block is idle; a write drops held bytes and resets the
// charset state. There is no clearing pass after reset.
module japanese_charset_converter_top
  import jcc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_conv_mode
);

  logic        accept;
  logic        q_full, q_not_empty, q_pop, q_push;
  bundle_t     q_wdata, q_rdata;
  front_stat_t fr_stat;

  // The mode register is always writable.
  assign cfg_ready = 1'b1;

  // The front takes a word whenever the queue can hold one more bundle.
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  jcc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid),
    .cfg_mode   (cfg_conv_mode),
    .accept     (accept),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .push_valid (q_push),
    .push_data  (q_wdata),
    .stat       (fr_stat)
  );

  jcc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rdata     (q_rdata)
  );

  jcc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_not_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

`ifndef SYNTHESIS
  // No input word ever expands beyond the worst case of the conversion rules.
  a_burst_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_wdata.cnt <= CNT_W'(WORST_BURST)))
    else $error("bundle longer than the worst-case expansion");

  // End of text leaves nothing held and the charset undetermined.
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last) |=> (fr_stat.held_cnt == 2'd0 && fr_stat.charset == CS_NONE))
    else $error("state not cleared after end of text");

  // Once the final word of a bundle leaves with nothing queued, the output goes idle.
  a_back_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last && !q_not_empty) |=> !out_valid)
    else $error("output valid without a queued bundle");
`endif

endmodule

// ----- bench/tb.sv -----
module tb;
  import jcc_pkg::*;

  // One source word or one converted word: a text byte and its end-of-text mark.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } text_word_t;

  // How the result side paces its ready signal when it is not in a long hold.
  typedef enum logic [1:0] {
    SINK_FREE,
    SINK_COIN,
    SINK_MOSTLY,
    SINK_PERIODIC
  } sink_style_t;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PRESSURE_HOLD = 150;
  localparam int PHASE_WORDS = 64;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_conv_mode = 2'd0;

  japanese_charset_converter_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_last      (out_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_conv_mode (cfg_conv_mode)
  );

  // The clock runs with a period of four time units.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Source words waiting to be offered, and converted words still owed by the block.
  text_word_t pending_text[$];
  text_word_t expected_out[$];

  int words_offered = 0;
  int words_taken = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int hold_reqs = 0;

  // Shadow copy of the converter state. It is updated when a source word is accepted
  // and when the mode register is written, so it always matches what the block has seen.
  mode_t      cur_mode = MODE_EUC_SJIS;
  logic [7:0] held [0:2];
  int         held_n = 0;
  charset_t   cset = CS_NONE;
  class_t     cls = CL_NONE;
  bit         aft_esc = 1'b0;
  logic [7:0] step_bytes[$];

  function automatic void emit(input logic [7:0] b);
    if (step_bytes.size() < MAX_OUT) step_bytes.push_back(b);
  endfunction

  function automatic bit in_span(input logic [7:0] v, input int lo_v, input int hi_v);
    return (v >= lo_v) && (v <= hi_v);
  endfunction

  function automatic void clear_text();
    held[0] = 8'h00;
    held[1] = 8'h00;
    held[2] = 8'h00;
    held_n = 0;
    cset = CS_NONE;
    cls = CL_NONE;
    aft_esc = 1'b0;
  endfunction

  function automatic void hold_one(input logic [7:0] b);
    held[0] = b;
    held_n = 1;
  endfunction

  function automatic bit euc_lead(input logic [7:0] b);
    return in_span(b, 'ha1, 'hfe) || (b == SS2);
  endfunction

  function automatic bit sjis_lead(input logic [7:0] b);
    return in_span(b, 'h81, 'h9f) || in_span(b, 'he0, 'hfc);
  endfunction

  // EUC kanji row and column map onto a Shift_JIS lead and trail byte.
  function automatic bit euc_to_sjis(input logic [7:0] f, input logic [7:0] s);
    int kr, kc, tl, ld;
    if (in_span(f, 'ha1, 'hfe) && in_span(s, 'ha1, 'hfe)) begin
      kr = f & 'h7f;
      kc = s & 'h7f;
      tl = kc + (((kr & 1) != 0) ? 'h1f : 'h7d);
      if (tl >= 'h7f) tl++;
      ld = ((kr - 'h21) >> 1) + 'h81;
      if (ld > 'h9f) ld += 'h40;
      emit(ld[7:0]);
      emit(tl[7:0]);
      return 1'b1;
    end
    if (f == SS2 && in_span(s, 'ha0, 'hdf)) begin
      emit(s);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // The trail byte decides whether the row is odd or even; 0x9f starts the even half.
  function automatic bit sjis_to_euc(input logic [7:0] f, input logic [7:0] s);
    int hv, lv;
    if (!in_span(s, 'h40, 'hfc) || s == 8'h7f) return 1'b0;
    hv = (f - ((f <= 8'h9f) ? 'h71 : 'hb1)) & 'hff;
    hv = ((hv << 1) + 1) & 'hff;
    lv = s;
    if (lv >= 'h9f) begin
      lv -= 'h7e;
      hv = (hv + 1) & 'hff;
    end else if (lv > 'h7f) begin
      lv -= 'h20;
    end else begin
      lv -= 'h1f;
    end
    emit(hv[7:0] | HI_BIT);
    emit(lv[7:0] | HI_BIT);
    return 1'b1;
  endfunction

  // An escape goes out only when the class of the emitted character changes.
  function automatic void mark_class(input class_t c);
    if (c != cls) begin
      cls = c;
      emit(ESC);
      if (c == CL_KANA) begin
        emit(CH_LPAREN);
        emit(CH_I);
      end else if (c == CL_KANJI) begin
        emit(CH_DOLLAR);
        emit(CH_B);
      end else begin
        emit(CH_LPAREN);
        emit(CH_B);
      end
    end
  endfunction

  function automatic void ascii_out(input logic [7:0] b);
    mark_class(CL_ASCII);
    emit(b);
  endfunction

  function automatic bit euc_to_jis(input logic [7:0] f, input logic [7:0] s);
    if (in_span(f, 'ha1, 'hfe) && in_span(s, 'ha1, 'hfe)) begin
      mark_class(CL_KANJI);
      emit(f & LOW7_MASK);
      emit(s & LOW7_MASK);
      return 1'b1;
    end
    if (f == SS2 && in_span(s, 'ha0, 'hdf)) begin
      mark_class(CL_KANA);
      emit(s & LOW7_MASK);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void jis_char(input logic [7:0] b, input charset_t cs, input bit after);
    if (cs == CS_KANA) begin
      emit(SS2);
      emit(b | HI_BIT);
    end else if (cs == CS_KANJI) begin
      hold_one(b);
      aft_esc = after;
    end else begin
      emit(b);
    end
  endfunction

  function automatic charset_t escape_charset(input logic [7:0] s, input logic [7:0] t);
    if (s == CH_DOLLAR && (t == CH_B || t == CH_AT)) return CS_KANJI;
    if (s == CH_LPAREN && t == CH_J) return CS_ROMAN;
    if (s == CH_LPAREN && t == CH_I) return CS_KANA;
    if (s == CH_LPAREN && t == CH_B) return CS_ASCII;
    return CS_NONE;
  endfunction

  function automatic void jis_step(input logic [7:0] b);
    charset_t cs;
    case (held_n)
      0: begin
        if (b == ESC) begin
          hold_one(b);
          aft_esc = 1'b0;
        end else begin
          jis_char(b, cset, 1'b0);
        end
      end
      1: begin
        if (held[0] == ESC && !aft_esc) begin
          held[1] = b;
          held_n = 2;
        end else begin
          emit(held[0] | HI_BIT);
          emit(b | HI_BIT);
          held_n = 0;
          aft_esc = 1'b0;
        end
      end
      2: begin
        held[2] = b;
        held_n = 3;
      end
      default: begin
        // A kanji designation followed by an 8-bit kana byte is read as kana once.
        cset = escape_charset(held[1], held[2]);
        cs = cset;
        if (cs == CS_KANJI && in_span(b, 'ha0, 'hdf)) cs = CS_KANA;
        held_n = 0;
        jis_char(b, cs, 1'b1);
      end
    endcase
  endfunction

  function automatic void first_byte(input logic [7:0] b);
    case (cur_mode)
      MODE_EUC_SJIS: begin
        if (euc_lead(b)) hold_one(b);
        else emit(b);
      end
      MODE_SJIS_EUC: begin
        if (in_span(b, 'ha0, 'hdf)) begin
          emit(SS2);
          emit(b);
        end else if (sjis_lead(b)) begin
          hold_one(b);
        end else begin
          emit(b);
        end
      end
      default: begin
        if (euc_lead(b)) hold_one(b);
        else ascii_out(b);
      end
    endcase
  endfunction

  // Works out the converted words for one accepted source word and queues them.
  function automatic void predict_conversion(input logic [7:0] b, input logic l);
    logic [7:0] h;
    bit         ok;
    text_word_t w;
    int         i;
    h = held[0];
    step_bytes.delete();
    if (cur_mode == MODE_JIS_EUC) begin
      jis_step(b);
    end else if (held_n != 0) begin
      held_n = 0;
      case (cur_mode)
        MODE_EUC_SJIS: ok = euc_to_sjis(h, b);
        MODE_SJIS_EUC: ok = sjis_to_euc(h, b);
        default:       ok = euc_to_jis(h, b);
      endcase
      if (!ok) begin
        // The held byte stands alone and the new byte is looked at afresh.
        if (cur_mode == MODE_EUC_JIS) ascii_out(h);
        else emit(h);
        first_byte(b);
      end
    end else begin
      first_byte(b);
    end
    if (l) begin
      if (held_n != 0) begin
        h = held[0];
        if (cur_mode == MODE_JIS_EUC) begin
          // A partial escape is dropped; a lone kanji byte is paired with zero.
          if (held_n == 1 && (h != ESC || aft_esc)) begin
            emit(h | HI_BIT);
            emit(HI_BIT);
          end
        end else if (cur_mode == MODE_EUC_JIS) begin
          ascii_out(h);
        end else begin
          emit(h);
        end
      end
      clear_text();
    end
    for (i = 0; i < step_bytes.size(); i++) begin
      w.data = step_bytes[i];
      w.last = (i == step_bytes.size() - 1);
      expected_out.push_back(w);
    end
  endfunction

  // A source word is taken at a rising edge where valid and ready are both high.
  always @(posedge clk) begin : word_accept
    if (rst_n && in_valid && in_ready) begin
      predict_conversion(in_byte, in_last);
      words_taken++;
    end
  end

  // The sender drives at the falling edge. It offers words in bursts of random length
  // with random gaps between them, and now and then a long burst with no gaps at all.
  // A word stays on the port unchanged until the accept block has counted it.
  int burst_left = 1;
  int gap_left = 0;

  always @(negedge clk) begin : word_driver
    text_word_t w;
    if (rst_n && words_offered == words_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_text.size() > 0) begin
        w = pending_text.pop_front();
        words_offered++;
        in_valid <= 1'b1;
        in_byte <= w.data;
        in_last <= w.last;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // The receiver picks a new pacing style at random at regular intervals. On request from the
  // sequence it holds ready low for a long stretch, which lets the block fill up and
  // push back on the source side; it also starts shorter holds of its own at random.
  sink_style_t sink_style = SINK_FREE;
  int          sink_cycle = 0;
  int          hold_left = 0;
  int          hold_seen = 0;

  always @(negedge clk) begin : result_sink
    bit rdy;
    sink_cycle++;
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = PRESSURE_HOLD;
    end else if (hold_left == 0 && $urandom_range(0, 599) == 0) begin
      hold_left = $urandom_range(30, 60);
    end
    if (sink_cycle % 250 == 0) sink_style = sink_style_t'($urandom_range(0, 3));
    if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else begin
      case (sink_style)
        SINK_FREE:   rdy = 1'b1;
        SINK_COIN:   rdy = $urandom_range(0, 1);
        SINK_MOSTLY: rdy = ($urandom_range(0, 3) != 0);
        default:     rdy = ((sink_cycle % 5) < 2);
      endcase
    end
    out_ready <= rdy;
  end

  // Every converted word is checked against the oldest word still owed.
  always @(posedge clk) begin : result_check
    text_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_out.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output word: byte %h last %b", out_byte, out_last);
      end else begin
        want = expected_out.pop_front();
        if (out_byte !== want.data || out_last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected byte %h last %b, got byte %h last %b",
                     want.data, want.last, out_byte, out_last);
        end
      end
    end
  end

  // A hung block ends the run here.
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  function automatic void queue_word(input logic [7:0] b, input logic l);
    text_word_t w;
    w.data = b;
    w.last = l;
    pending_text.push_back(w);
  endfunction

  // End-of-text marks land on random words, so they also cut pairs and escapes short.
  function automatic logic text_end_roll();
    return ($urandom_range(0, 23) == 0);
  endfunction

  function automatic logic [7:0] rand_byte(input int lo_v, input int hi_v);
    int v;
    v = $urandom_range(lo_v, hi_v);
    return v[7:0];
  endfunction

  // Random text for one mode. Most of it is well formed for the source encoding, so
  // the pair and escape paths are reached, and the rest is arbitrary bytes.
  task automatic fill_random(input mode_t m, input int count);
    int         start;
    int         pick;
    int         sel;
    logic [7:0] e1, e2, tr;
    start = pending_text.size();
    while (pending_text.size() - start < count) begin
      pick = $urandom_range(0, 15);
      if (m == MODE_EUC_SJIS || m == MODE_EUC_JIS) begin
        if (pick < 5) begin
          queue_word(rand_byte('h00, 'h7f), text_end_roll());
        end else if (pick < 11) begin
          queue_word(rand_byte('ha1, 'hfe), text_end_roll());
          queue_word(rand_byte('ha1, 'hfe), text_end_roll());
        end else if (pick < 14) begin
          queue_word(SS2, text_end_roll());
          queue_word(rand_byte('ha0, 'hdf), text_end_roll());
        end else begin
          queue_word(rand_byte('h00, 'hff), text_end_roll());
        end
      end else if (m == MODE_SJIS_EUC) begin
        if (pick < 5) begin
          queue_word(rand_byte('h00, 'h7f), text_end_roll());
        end else if (pick < 8) begin
          queue_word(rand_byte('ha0, 'hdf), text_end_roll());
        end else if (pick < 14) begin
          if ($urandom_range(0, 1) == 0) queue_word(rand_byte('h81, 'h9f), text_end_roll());
          else queue_word(rand_byte('he0, 'hfc), text_end_roll());
          tr = rand_byte('h40, 'hfc);
          if (tr == 8'h7f) tr = 8'h80;
          queue_word(tr, text_end_roll());
        end else begin
          queue_word(rand_byte('h00, 'hff), text_end_roll());
        end
      end else begin
        if (pick < 3) begin
          sel = $urandom_range(0, 5);
          case (sel)
            0: begin e1 = CH_DOLLAR; e2 = CH_B; end
            1: begin e1 = CH_DOLLAR; e2 = CH_AT; end
            2: begin e1 = CH_LPAREN; e2 = CH_J; end
            3: begin e1 = CH_LPAREN; e2 = CH_I; end
            4: begin e1 = CH_LPAREN; e2 = CH_B; end
            default: begin e1 = rand_byte('h00, 'hff); e2 = rand_byte('h00, 'hff); end
          endcase
          queue_word(ESC, text_end_roll());
          queue_word(e1, text_end_roll());
          queue_word(e2, text_end_roll());
        end else if (pick < 12) begin
          queue_word(rand_byte('h21, 'h7e), text_end_roll());
          queue_word(rand_byte('h21, 'h7e), text_end_roll());
        end else if (pick < 14) begin
          queue_word(rand_byte('ha0, 'hdf), text_end_roll());
        end else begin
          queue_word(rand_byte('h00, 'hff), text_end_roll());
        end
      end
    end
  endtask

  // Waits until every source word is taken and every converted word has come back,
  // then lets the block settle so that words that produce no output are finished too.
  task automatic wait_idle();
    while (pending_text.size() != 0 || in_valid || expected_out.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // A mode write also drops held bytes and resets the charset state in the block.
  task automatic write_mode(input mode_t m);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_conv_mode <= m;
    do @(posedge clk); while (!cfg_ready);
    cur_mode = m;
    clear_text();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : sequence_main
    int p;
    clear_text();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // EUC to Shift_JIS: a kanji pair, a lead rejected by a zero byte, a lead at the end.
    write_mode(MODE_EUC_SJIS);
    queue_word(8'hb0, 1'b0); queue_word(8'ha1, 1'b0);
    queue_word(8'ha1, 1'b0); queue_word(8'h00, 1'b0);
    queue_word(8'hfe, 1'b1);
    wait_idle();

    // Shift_JIS to EUC: a trail right at the threshold, a byte that is no lead at all,
    // and a lead cut off by the end of text.
    write_mode(MODE_SJIS_EUC);
    queue_word(8'h9f, 1'b0); queue_word(8'h9f, 1'b0);
    queue_word(8'hff, 1'b0); queue_word(8'he0, 1'b1);
    wait_idle();

    // EUC to JIS: the first character forces an escape, kana switches class, and a
    // lead at the end goes out as a single byte.
    write_mode(MODE_EUC_JIS);
    queue_word(8'h41, 1'b0); queue_word(8'h8e, 1'b0);
    queue_word(8'hb1, 1'b0); queue_word(8'ha4, 1'b1);
    wait_idle();

    // JIS to EUC: kana right after a kanji designation, an unknown escape, an escape
    // byte taken as data after an escape, a lone kanji byte at the end, and a partial
    // escape at the end.
    write_mode(MODE_JIS_EUC);
    queue_word(ESC, 1'b0); queue_word(CH_DOLLAR, 1'b0);
    queue_word(CH_B, 1'b0); queue_word(8'hb1, 1'b0);
    queue_word(ESC, 1'b0); queue_word(CH_LPAREN, 1'b0);
    queue_word(8'h5a, 1'b0); queue_word(8'h7f, 1'b0);
    queue_word(ESC, 1'b0); queue_word(CH_DOLLAR, 1'b0);
    queue_word(CH_B, 1'b0); queue_word(ESC, 1'b0);
    queue_word(8'h22, 1'b0); queue_word(8'h30, 1'b1);
    queue_word(ESC, 1'b0); queue_word(CH_DOLLAR, 1'b1);
    wait_idle();

    // Random text, cycling through every mode twice. The first phase also holds the
    // receiver off for a long stretch while the sender keeps offering words.
    for (p = 0; p < 8; p++) begin
      write_mode(mode_t'((p + 3) % 4));
      fill_random(cur_mode, PHASE_WORDS);
      if (p == 0) hold_reqs++;
      wait_idle();
    end

    if (mismatches == 0 && expected_out.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/jcc_pkg.sv
rtl/jcc_front.sv
rtl/jcc_queue.sv
rtl/jcc_back.sv
rtl/japanese_charset_converter_top.sv
bench/tb.sv
